// ===== sv/glos_pkg.sv =====
// Shared types, constants and the microcode table for the grid line-of-sight checker.
// Depends on nothing; used by grid_line_of_sight_check.sv and the testbench.
package glos_pkg;

  // Default grid side; storage is MAX_SIDE x MAX_SIDE one-bit cells.
  localparam int unsigned MAX_SIDE_DEF = 256;

  // Fixed field widths of the item and configuration ports.
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  // Absolute coordinate difference and Bresenham error term.
  localparam int unsigned DELTA_W   = COORD_W + 1;
  localparam int unsigned ERR_W     = COORD_W + 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  // Input function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    U_CLEAR   = 3'd0,
    U_IDLE    = 3'd1,
    U_DISPATCH = 3'd2,
    U_FETCH   = 3'd3,
    U_WALK    = 3'd4,
    U_FREE    = 3'd5,
    U_BLOCKED = 3'd6,
    U_WRITE   = 3'd7
  } upc_e;

  // Datapath operations selected by one control word.
  typedef enum logic [2:0] {
    OP_NOP         = 3'd0,
    OP_CLEAR       = 3'd1,
    OP_LOAD        = 3'd2,
    OP_INIT        = 3'd3,
    OP_FETCH       = 3'd4,
    OP_RES_FREE    = 3'd5,
    OP_RES_BLOCKED = 3'd6,
    OP_WRITE       = 3'd7
  } uop_e;

  // Jump conditions.
  localparam int unsigned COND_W = 3;
  typedef enum logic [COND_W-1:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_START  = 3'd2,
    C_IS_WRITE  = 3'd3,
    C_BLOCKED   = 3'd4,
    C_MORE      = 3'd5,
    C_CLR_MORE  = 3'd6
  } cond_e;

  // One control word: an operation and two prioritized conditional jumps.
  // When neither jump is taken the step counter advances by one.
  typedef struct packed {
    uop_e  op;
    cond_e j1_cond;
    upc_e  j1_tgt;
    cond_e j2_cond;
    upc_e  j2_tgt;
  } ucode_t;

  // The microprogram.
  function automatic ucode_t ucode_rom(upc_e pc);
    ucode_t w;
    w = '{op: OP_NOP, j1_cond: C_NEVER, j1_tgt: U_IDLE, j2_cond: C_NEVER, j2_tgt: U_IDLE};
    case (pc)
      // Sweep the grid to free after reset.
      U_CLEAR: begin
        w.op = OP_CLEAR; w.j1_cond = C_CLR_MORE; w.j1_tgt = U_CLEAR;
      end
      // Wait for an item and capture it.
      U_IDLE: begin
        w.op = OP_LOAD; w.j1_cond = C_NO_START; w.j1_tgt = U_IDLE;
      end
      // Set up the line walk; writes branch off.
      U_DISPATCH: begin
        w.op = OP_INIT; w.j1_cond = C_IS_WRITE; w.j1_tgt = U_WRITE;
      end
      // Read the first cell.
      U_FETCH: begin
        w.op = OP_FETCH;
      end
      // Test the cell read last cycle while reading the next one.
      U_WALK: begin
        w.op = OP_FETCH;
        w.j1_cond = C_BLOCKED; w.j1_tgt = U_BLOCKED;
        w.j2_cond = C_MORE;    w.j2_tgt = U_WALK;
      end
      U_FREE: begin
        w.op = OP_RES_FREE; w.j1_cond = C_ALWAYS; w.j1_tgt = U_IDLE;
      end
      U_BLOCKED: begin
        w.op = OP_RES_BLOCKED; w.j1_cond = C_ALWAYS; w.j1_tgt = U_IDLE;
      end
      U_WRITE: begin
        w.op = OP_WRITE; w.j1_cond = C_ALWAYS; w.j1_tgt = U_IDLE;
      end
      default: begin
        w.j1_cond = C_ALWAYS; w.j1_tgt = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/glos_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instantiated by grid_line_of_sight_check.sv.
module glos_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/grid_line_of_sight_check.sv =====
// Top level of the grid line-of-sight checker: microcode sequencer, walk datapath, grid RAM.
// Depends on glos_pkg.sv and glos_ram.sv.
//
//  Channel  | Ports                                               | Handshake
//  ---------+-----------------------------------------------------+---------------------------
//  item in  | func_i start_x_i start_y_i end_x_i end_y_i           | start && !busy
//           | occupied_i                                          |
//  result   | line_free_o is_check_result_o                       | done_o, one cycle
//  config   | cfg_index_i cfg_data_i                              | cfg_valid_i && cfg_ready_o
//
// A write item passes from acceptance through the dispatch step to the write step, which
// gives its result strobe. A check item passes through the dispatch and fetch steps, then
// takes one walk step per visited cell (at most the longer axis of the segment plus one)
// before its free or blocked result step. Each result step returns to idle, where the
// next item is taken. After reset the grid RAM is swept to free, one cell per cycle, over
// all MAX_SIDE * MAX_SIDE cells; busy stays high meanwhile, configuration writes are taken.
// The result strobe cannot be stalled.
module grid_line_of_sight_check #(
  parameter int unsigned MAX_SIDE = glos_pkg::MAX_SIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Item channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic signed [glos_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [glos_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [glos_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [glos_pkg::COORD_W-1:0] end_y_i,
  input  logic                                occupied_i,
  // Result channel.
  output logic                                done_o,
  output logic                                line_free_o,
  output logic                                is_check_result_o,
  // Configuration channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [glos_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [glos_pkg::DIM_W-1:0]          cfg_data_i
);

  localparam int unsigned CW      = glos_pkg::COORD_W;
  localparam int unsigned DW      = glos_pkg::DELTA_W;
  localparam int unsigned EW      = glos_pkg::ERR_W;
  localparam int unsigned Depth   = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW      = $clog2(Depth);
  localparam int unsigned SW      = $clog2(MAX_SIDE);
  localparam logic [CW-1:0] SideLim = CW'(MAX_SIDE);
  localparam logic [AW-1:0] ClrLast = AW'(Depth - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [glos_pkg::DIM_W-1:0] grid_width_q, grid_width_d;
  logic [glos_pkg::DIM_W-1:0] grid_height_q, grid_height_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        glos_pkg::REG_GRID_WIDTH:  grid_width_d  = cfg_data_i;
        glos_pkg::REG_GRID_HEIGHT: grid_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= glos_pkg::DIM_W'(256);
      grid_height_q <= glos_pkg::DIM_W'(256);
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
    end
  end

  // Dimensions above the storage side act as the storage side.
  logic [CW-1:0] eff_w, eff_h;
  assign eff_w = (CW'(grid_width_q)  > SideLim) ? SideLim : CW'(grid_width_q);
  assign eff_h = (CW'(grid_height_q) > SideLim) ? SideLim : CW'(grid_height_q);

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers.
  glos_pkg::upc_e   upc_q, upc_d;
  glos_pkg::ucode_t uc;
  logic [AW-1:0]    clr_q, clr_d;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d, x1_q, x1_d, y1_q, y1_d;
  logic                 func_q, func_d, occ_q, occ_d;
  logic [DW-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                 sxn_q, sxn_d, syn_q, syn_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 inside_q, inside_d, last_q, last_d;

  logic                 ram_rd;
  logic                 ram_we, ram_re, ram_wdata;
  logic [AW-1:0]        ram_waddr, cell_addr;

  assign uc = glos_pkg::ucode_rom(upc_q);

  // ---------------------------------------------------------------------------
  // Current cell: bounds test and grid address.
  logic cell_inside;
  assign cell_inside = !x_q[CW-1] && ($unsigned(x_q) < eff_w) &&
                       !y_q[CW-1] && ($unsigned(y_q) < eff_h);
  assign cell_addr   = AW'(y_q[SW-1:0]) * AW'(MAX_SIDE) + AW'(x_q[SW-1:0]);

  // Setup arithmetic: absolute differences and step directions.
  logic signed [DW-1:0] diff_x, diff_y;
  logic [DW-1:0]        abs_x, abs_y;
  assign diff_x = DW'(x1_q) - DW'(x_q);
  assign diff_y = DW'(y1_q) - DW'(y_q);
  assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

  // One Bresenham step from the current cell.
  logic signed [EW:0]   e2, neg_dy, dx_s;
  logic                 step_x, step_y;
  assign e2     = {err_q, 1'b0};
  assign neg_dy = -$signed((EW+1)'(dy_q));
  assign dx_s   = $signed((EW+1)'(dx_q));
  assign step_x = e2 > neg_dy;
  assign step_y = e2 < dx_s;

  // ---------------------------------------------------------------------------
  // Jump conditions.
  logic [(2**glos_pkg::COND_W)-1:0] cond_v;
  always_comb begin
    cond_v = '0;
    cond_v[glos_pkg::C_ALWAYS]   = 1'b1;
    cond_v[glos_pkg::C_NO_START] = !start;
    cond_v[glos_pkg::C_IS_WRITE] = (func_q == glos_pkg::FUNC_WRITE);
    cond_v[glos_pkg::C_BLOCKED]  = !inside_q || ram_rd;
    cond_v[glos_pkg::C_MORE]     = !last_q;
    cond_v[glos_pkg::C_CLR_MORE] = (clr_q != ClrLast);
  end

  // Next step.
  always_comb begin
    if (cond_v[uc.j1_cond]) begin
      upc_d = uc.j1_tgt;
    end else if (cond_v[uc.j2_cond]) begin
      upc_d = uc.j2_tgt;
    end else begin
      upc_d = glos_pkg::upc_e'(upc_q + 3'd1);
    end
  end

  // Datapath actions selected by the control word.
  always_comb begin
    clr_d    = clr_q;
    x_d      = x_q;
    y_d      = y_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    func_d   = func_q;
    occ_d    = occ_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    err_d    = err_q;
    inside_d = inside_q;
    last_d   = last_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = occ_q;
    case (uc.op)
      glos_pkg::OP_CLEAR: begin
        // The sweep address stops on the last cell.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = (clr_q == ClrLast) ? clr_q : clr_q + AW'(1);
      end
      glos_pkg::OP_LOAD: begin
        if (start) begin
          x_d    = start_x_i;
          y_d    = start_y_i;
          x1_d   = end_x_i;
          y1_d   = end_y_i;
          func_d = func_i;
          occ_d  = occupied_i;
        end
      end
      glos_pkg::OP_INIT: begin
        dx_d  = abs_x;
        dy_d  = abs_y;
        sxn_d = !(diff_x > 0);
        syn_d = !(diff_y > 0);
        err_d = EW'(abs_x) - EW'(abs_y);
      end
      glos_pkg::OP_FETCH: begin
        // Read the current cell, note its flags, then move to the next cell.
        ram_re   = cell_inside;
        inside_d = cell_inside;
        last_d   = (x_q == x1_q) && (y_q == y1_q);
        if (step_x) begin
          x_d = sxn_q ? x_q - CW'(1) : x_q + CW'(1);
        end
        if (step_y) begin
          y_d = syn_q ? y_q - CW'(1) : y_q + CW'(1);
        end
        err_d = err_q - (step_x ? EW'(dy_q) : EW'(0)) + (step_y ? EW'(dx_q) : EW'(0));
      end
      glos_pkg::OP_WRITE: begin
        ram_we = cell_inside;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= glos_pkg::U_CLEAR;
      clr_q <= '0;
    end else begin
      upc_q <= upc_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    func_q   <= func_d;
    occ_q    <= occ_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sxn_q    <= sxn_d;
    syn_q    <= syn_d;
    err_q    <= err_d;
    inside_q <= inside_d;
    last_q   <= last_d;
  end

  // ---------------------------------------------------------------------------
  // Occupancy grid storage.
  glos_ram #(
    .WIDTH (1),
    .DEPTH (Depth)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_addr),
    .rdata_o (ram_rd)
  );

  // ---------------------------------------------------------------------------
  // Handshake and result outputs.
  always_comb begin
    busy              = (upc_q != glos_pkg::U_IDLE);
    done_o            = uc.op inside {glos_pkg::OP_RES_FREE, glos_pkg::OP_RES_BLOCKED,
                                      glos_pkg::OP_WRITE};
    line_free_o       = (uc.op == glos_pkg::OP_RES_FREE);
    is_check_result_o = uc.op inside {glos_pkg::OP_RES_FREE, glos_pkg::OP_RES_BLOCKED};
  end

  // ---------------------------------------------------------------------------
  // Assertions.

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but block not busy next cycle");

  // A free last cell during the walk leads straight to a free result.
  a_walk_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == glos_pkg::U_WALK) && inside_q && !ram_rd && last_q |=> done_o && line_free_o)
    else $error("walk reached a free end cell without a free result");

  // The block only goes idle once the clearing sweep has covered the grid.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> clr_q == ClrLast)
    else $error("block idle before the grid sweep finished");

  // Outside the sweep the grid is written only by a write item.
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && (upc_q != glos_pkg::U_CLEAR) |-> (upc_q == glos_pkg::U_WRITE) && !func_q)
    else $error("grid written outside a write item");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for grid_line_of_sight_check: grid writes, line checks, size changes.
// Depends on glos_pkg.sv and the RTL of the block; it carries its own model of the grid walk.
`timescale 1ns / 100ps

module testbench;

  localparam int GRID_CELLS      = glos_pkg::MAX_SIDE_DEF * glos_pkg::MAX_SIDE_DEF;
  localparam int HOT_SPAN        = 20;
  localparam int ITEMS_PER_PHASE = 93;
  localparam int RANDOM_PHASES   = 7;
  // The limit covers the clearing sweep after reset, which sees no handshake.
  localparam int WATCHDOG_LIMIT  = 300000;

  typedef struct {
    logic line_free;
    logic is_check;
  } los_answer_t;

  // Grid model and queue of expected answers, one per accepted item.
  class los_scoreboard;
    bit                         occupancy_q [GRID_CELLS];
    logic [glos_pkg::DIM_W-1:0] width_reg;
    logic [glos_pkg::DIM_W-1:0] height_reg;
    los_answer_t                answer_q [$];
    int unsigned                result_count;
    int unsigned                error_count;

    function new();
      width_reg    = glos_pkg::DIM_W'(glos_pkg::MAX_SIDE_DEF);
      height_reg   = glos_pkg::DIM_W'(glos_pkg::MAX_SIDE_DEF);
      result_count = 0;
      error_count  = 0;
    endfunction

    // A register value above the storage side acts as the full side.
    function int eff_side(logic [glos_pkg::DIM_W-1:0] r);
      return (r > glos_pkg::MAX_SIDE_DEF) ? glos_pkg::MAX_SIDE_DEF : int'(r);
    endfunction

    function bit cell_inside(int x, int y);
      return x >= 0 && x < eff_side(width_reg) && y >= 0 && y < eff_side(height_reg);
    endfunction

    function bit cell_open(int x, int y);
      if (!cell_inside(x, y))
        return 1'b0;
      return !occupancy_q[y * glos_pkg::MAX_SIDE_DEF + x];
    endfunction

    // Bresenham walk over both endpoints; stops at the first blocked cell.
    function bit walk_is_free(int x0, int y0, int x1, int y1);
      int dx, dy, sx, sy, err, e2;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx  = (x0 < x1) ? 1 : -1;
      sy  = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      for (int step = 0; step < 8192; step++) begin
        if (!cell_open(x0, y0))
          return 1'b0;
        if (x0 == x1 && y0 == y1)
          break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x0  += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y0  += sy;
        end
      end
      return 1'b1;
    endfunction

    function void set_dim(logic [glos_pkg::CFG_IDX_W-1:0] idx,
                          logic [glos_pkg::DIM_W-1:0] value);
      if (idx == glos_pkg::REG_GRID_WIDTH)
        width_reg = value;
      else if (idx == glos_pkg::REG_GRID_HEIGHT)
        height_reg = value;
    endfunction

    // Apply an accepted item to the grid and queue its answer.
    function void note_item(logic fn, logic signed [glos_pkg::COORD_W-1:0] sx_in,
                            logic signed [glos_pkg::COORD_W-1:0] sy_in,
                            logic signed [glos_pkg::COORD_W-1:0] ex_in,
                            logic signed [glos_pkg::COORD_W-1:0] ey_in, logic occ);
      los_answer_t a;
      int          x, y;
      x = int'(sx_in);
      y = int'(sy_in);
      if (fn == glos_pkg::FUNC_WRITE) begin
        if (cell_inside(x, y))
          occupancy_q[y * glos_pkg::MAX_SIDE_DEF + x] = occ;
        a.line_free = 1'b0;
        a.is_check  = 1'b0;
      end else begin
        a.line_free = walk_is_free(x, y, int'(ex_in), int'(ey_in));
        a.is_check  = 1'b1;
      end
      answer_q.insert(answer_q.size(), a);
    endfunction

    function int pending();
      return answer_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t: result %0d mismatch: %s", $time, result_count, msg);
      error_count++;
    endtask

    // Compare one result strobe with the oldest expected answer.
    task check_result(logic lf, logic ic);
      los_answer_t a;
      result_count++;
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("result with no item pending (line_free=%b kind=%b)", lf, ic));
        return;
      end
      a = answer_q.pop_front();
      if (ic !== a.is_check)
        report_mismatch($sformatf("is_check_result %b, expected %b", ic, a.is_check));
      if (lf !== a.line_free)
        report_mismatch($sformatf("line_free %b, expected %b", lf, a.line_free));
    endtask
  endclass

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 start       = 1'b0;
  logic                                 busy;
  logic                                 func_i      = glos_pkg::FUNC_WRITE;
  logic signed [glos_pkg::COORD_W-1:0]  start_x_i   = '0;
  logic signed [glos_pkg::COORD_W-1:0]  start_y_i   = '0;
  logic signed [glos_pkg::COORD_W-1:0]  end_x_i     = '0;
  logic signed [glos_pkg::COORD_W-1:0]  end_y_i     = '0;
  logic                                 occupied_i  = 1'b0;
  logic                                 done_o;
  logic                                 line_free_o;
  logic                                 is_check_result_o;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [glos_pkg::CFG_IDX_W-1:0]       cfg_index_i = glos_pkg::REG_GRID_WIDTH;
  logic [glos_pkg::DIM_W-1:0]           cfg_data_i  = '0;

  los_scoreboard sb = new();
  int            quiet_cycles = 0;

  grid_line_of_sight_check uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .occupied_i        (occupied_i),
    .done_o            (done_o),
    .line_free_o       (line_free_o),
    .is_check_result_o (is_check_result_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample every handshake at the clock edge and keep the model in step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_result(line_free_o, is_check_result_o);
      if (start && !busy)
        sb.note_item(func_i, start_x_i, start_y_i, end_x_i, end_y_i, occupied_i);
      if (cfg_valid_i && cfg_ready_o)
        sb.set_dim(cfg_index_i, cfg_data_i);
    end
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: too long without any handshake ends the run.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Present one item and hold it until the block takes it; start stays high on return.
  task automatic drive_item(input logic fn, input logic signed [glos_pkg::COORD_W-1:0] sx,
                            input logic signed [glos_pkg::COORD_W-1:0] sy,
                            input logic signed [glos_pkg::COORD_W-1:0] ex,
                            input logic signed [glos_pkg::COORD_W-1:0] ey, input logic occ);
    start      <= 1'b1;
    func_i     <= fn;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    occupied_i <= occ;
    @(posedge clk_i);
    while (busy)
      @(posedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold the sender off until every expected answer has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0)
      @(posedge clk_i);
  endtask

  // Write both grid dimensions back to back; the block must be idle.
  task automatic set_grid(input logic [glos_pkg::DIM_W-1:0] w,
                          input logic [glos_pkg::DIM_W-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= glos_pkg::REG_GRID_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    cfg_index_i <= glos_pkg::REG_GRID_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinate in a small hot corner of the grid half the time, otherwise on or just past its edges or anywhere.
  function automatic logic signed [glos_pkg::COORD_W-1:0] pick_coord(input int side);
    int v;
    int hot;
    hot = (side < HOT_SPAN) ? side : HOT_SPAN;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = -1;
          1:       v = 0;
          2:       v = side - 1;
          default: v = side;
        endcase
      end
      2, 3, 4, 5, 6: v = (side == 0) ? $urandom_range(0, 3) : $urandom_range(0, hot - 1);
      default:       v = (side == 0) ? $urandom_range(0, 3) : $urandom_range(0, side - 1);
    endcase
    return glos_pkg::COORD_W'(v);
  endfunction

  task automatic random_item(input int w_side, input int h_side);
    logic                                fn;
    logic                                occ;
    logic signed [glos_pkg::COORD_W-1:0] sx, sy, ex, ey;
    fn  = ($urandom_range(0, 1) == 0) ? glos_pkg::FUNC_WRITE : glos_pkg::FUNC_CHECK;
    sx  = pick_coord(w_side);
    sy  = pick_coord(h_side);
    ex  = pick_coord(w_side);
    ey  = pick_coord(h_side);
    occ = ($urandom_range(0, 9) < 4) ? 1'b1 : 1'b0;
    drive_item(fn, sx, sy, ex, ey, occ);
  endtask

  initial begin : stimulus
    logic [glos_pkg::DIM_W-1:0] w_reg, h_reg;
    int                         burst_left;

    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset grid size: single-cell segments, long walks, far coordinates.
    drive_item(glos_pkg::FUNC_WRITE, 0, 0, 0, 0, 1'b1);
    drive_item(glos_pkg::FUNC_CHECK, 0, 0, 0, 0, 1'b0);
    drive_item(glos_pkg::FUNC_WRITE, 0, 0, 0, 0, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 0, 0, 0, 0, 1'b1);
    drive_item(glos_pkg::FUNC_WRITE, 255, 255, 0, 0, 1'b1);
    drive_item(glos_pkg::FUNC_CHECK, 255, 0, 255, 255, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 0, 1, 254, 1, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, -1024, -1024, 1023, 1023, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 1023, 1023, 0, 0, 1'b1);
    // Writes off the grid are acknowledged but change nothing.
    drive_item(glos_pkg::FUNC_WRITE, -1, 5, 0, 0, 1'b1);
    drive_item(glos_pkg::FUNC_WRITE, 256, 3, 0, 0, 1'b1);
    drive_item(glos_pkg::FUNC_WRITE, 1023, -1024, -1, 1023, 1'b1);
    drive_item(glos_pkg::FUNC_CHECK, 10, 0, 0, 10, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 3, 0, 5, 200, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 250, 250, 300, 260, 1'b0);
    drive_item(glos_pkg::FUNC_WRITE, 100, 100, 0, 0, 1'b1);

    // Shrinking keeps stored cells, but they read as blocked outside the new bounds.
    drain_results();
    set_grid(50, 50);
    drive_item(glos_pkg::FUNC_CHECK, 100, 100, 100, 100, 1'b0);
    drive_item(glos_pkg::FUNC_WRITE, 100, 100, 0, 0, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 0, 0, 49, 49, 1'b0);

    // Oversized registers act as the full side; the cell kept above is still occupied.
    drain_results();
    set_grid(511, 300);
    drive_item(glos_pkg::FUNC_CHECK, 100, 100, 100, 100, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 255, 0, 255, 254, 1'b0);

    // A zero dimension leaves no cell inside the grid.
    drain_results();
    set_grid(0, 256);
    drive_item(glos_pkg::FUNC_CHECK, 0, 0, 0, 0, 1'b0);
    drive_item(glos_pkg::FUNC_WRITE, 0, 0, 0, 0, 1'b1);

    // A one-cell grid.
    drain_results();
    set_grid(1, 1);
    drive_item(glos_pkg::FUNC_CHECK, 0, 0, 0, 0, 1'b0);
    drive_item(glos_pkg::FUNC_CHECK, 0, 0, 1, 0, 1'b0);

    // Random part: several grid sizes, bursts of items with random gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          w_reg = 256;
          h_reg = 256;
        end
        1: begin
          w_reg = 16;
          h_reg = 16;
        end
        2: begin
          w_reg = 1;
          h_reg = 256;
        end
        3: begin
          w_reg = 256;
          h_reg = 1;
        end
        4: begin
          w_reg = 0;
          h_reg = 7;
        end
        5: begin
          w_reg = 511;
          h_reg = 300;
        end
        default: begin
          w_reg = glos_pkg::DIM_W'($urandom_range(1, 256));
          h_reg = glos_pkg::DIM_W'($urandom_range(1, 256));
        end
      endcase
      drain_results();
      set_grid(w_reg, h_reg);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
          if ($urandom_range(0, 19) == 0)
            drain_results();
          else
            idle_sender($urandom_range(1, 25));
        end
        burst_left--;
        random_item(sb.eff_side(w_reg), sb.eff_side(h_reg));
      end
    end

    // Let the last answers come back, then keep watching for stray strobes before the verdict.
    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/glos_pkg.sv
sv/glos_ram.sv
sv/grid_line_of_sight_check.sv
sim/testbench.sv
